>>> design/fvpd_pkg.sv
// Package for the FOC voltage to phase duty block.
// Shared payload types, fixed-point constants and register codes.
// No dependencies.
`default_nettype none

package fvpd_pkg;

   localparam int ANGLE_FRAC_BITS = 16;
   localparam int DUTY_BITS       = 16;

   // quarter-wave sine polynomial coefficients, Q15
   localparam int SIN_A     = 51472;
   localparam int SIN_B     = 21024;
   localparam int SIN_C     = 2320;
   localparam int SIN_ONE   = 32768;
   localparam int SQRT3_Q16 = 113512;

   localparam logic [15:0] BUS_RESET = 16'd3072;

   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_BUS_VOLTAGE = 1'b0;

   // remainder width of the duty divider (remainder stays below bus << 17)
   localparam int REM_W = 33;
   localparam int NUM_PHASES = 3;

   typedef struct packed {
      logic signed [31:0] elec_angle;
      logic signed [15:0] q_voltage;
   } req_type;

   typedef struct packed {
      logic [15:0] duty_a;
      logic [15:0] duty_b;
      logic [15:0] duty_c;
   } rsp_type;

   typedef struct packed {
      logic [NUM_PHASES-1:0][REM_W-1:0]     rem;
      logic [NUM_PHASES-1:0][DUTY_BITS-1:0] quo;
      logic [NUM_PHASES-1:0]                zero;
      logic [NUM_PHASES-1:0]                full;
   } div_type;

endpackage

`default_nettype wire

>>> design/fvpd_div_step.sv
// One registered restoring-division step for the three phase duties.
// Depends on fvpd_pkg.
`default_nettype none

module fvpd_div_step
   import fvpd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  wire logic [32:0]   den,
   input  wire div_type       d_in,
   output      div_type       d_out
);

   div_type step_ff;
   div_type step_in;

   always_comb begin
      logic [REM_W:0] r2;
      logic           ge;
      step_in = d_in;
      for (int p = 0; p < NUM_PHASES; p++) begin
         r2 = {d_in.rem[p], 1'b0};
         ge = (r2 >= {1'b0, den});
         step_in.rem[p] = ge ? REM_W'(r2 - {1'b0, den}) : REM_W'(r2);
         step_in.quo[p] = {d_in.quo[p][DUTY_BITS-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff.zero <= '0;
         step_ff.full <= '0;
      end else if (en) begin
         step_ff.zero <= step_in.zero;
         step_ff.full <= step_in.full;
      end
      if (en) begin
         step_ff.rem <= step_in.rem;
         step_ff.quo <= step_in.quo;
      end
   end

   assign d_out = step_ff;

endmodule

`default_nettype wire

>>> design/foc_voltage_to_phase_duty_top.sv
// FOC output stage: inverse Park and Clarke transforms, then phase duties.
// Depends on fvpd_pkg and fvpd_div_step.
//
// Usage:
//   req channel: elec_angle (2^-16 turn) and q_voltage (Q8.8 V), one
//   transaction per cycle when req_stall is low.
//   rsp channel: duty_a/b/c in Q0.16, one transaction per request, in order.
//   csr port: APB-style, bus_voltage (Q8.8 V) at address 0; write only while
//   the pipeline is empty.
// Pipeline: 25 register stages (8 arithmetic stages, 16 divider steps,
//   one output register).
// Throughput: one transaction per cycle while rsp_stall is low; the 16-step
//   restoring divider (one quotient bit per stage) sets the depth.
// A stalled response holds in the output register; bubbles inside the
//   pipeline still collapse, so requests keep entering until every stage
//   holds a transaction, and then req_stall rises.
// Reset clears all valid bits and sets bus_voltage to 12 V.
// A zero bus voltage gives all duties zero.
`default_nettype none

module foc_voltage_to_phase_duty_top
   import fvpd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire req_type               req_payload,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      rsp_type               rsp_payload,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output      logic [31:0]           csr_prdata,
   output      logic                  csr_pready
);

   localparam int NARITH = 8;
   localparam int NSTG   = NARITH + DUTY_BITS + 1;

   typedef struct packed {
      logic [1:0][15:0]   z;
      logic [1:0]         neg;
      logic signed [16:0] q2;
   } s0_type;

   typedef struct packed {
      logic [1:0][15:0]   z;
      logic [1:0][15:0]   z2;
      logic [1:0]         neg;
      logic signed [16:0] q2;
   } s1_type;

   typedef struct packed {
      logic [1:0][15:0]   z;
      logic [1:0][15:0]   z2;
      logic [1:0][15:0]   r1;
      logic [1:0]         neg;
      logic signed [16:0] q2;
   } s2_type;

   typedef struct packed {
      logic [1:0][15:0]   z;
      logic [1:0][15:0]   r2;
      logic [1:0]         neg;
      logic signed [16:0] q2;
   } s3_type;

   typedef struct packed {
      logic [1:0][16:0]   sc;
      logic signed [16:0] q2;
   } s4_type;

   typedef struct packed {
      logic signed [33:0] alpha;
      logic signed [33:0] beta;
   } s5_type;

   typedef struct packed {
      logic signed [33:0] alpha;
      logic signed [51:0] bm;
   } s6_type;

   // configuration register
   logic [15:0] bus_ff;
   logic        csr_wr;

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_BUS_VOLTAGE) ? {16'h0, bus_ff} : 32'h0;

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_ff <= BUS_RESET;
      end else if (csr_wr && csr_paddr[2] == CSR_IDX_BUS_VOLTAGE) begin
         bus_ff <= csr_pwdata[15:0];
      end
   end

   // valid chain with bubble collapse
   logic [NSTG-1:0] v_ff;
   logic [NSTG-1:0] adv;

   always_comb begin
      adv[NSTG-1] = !v_ff[NSTG-1] || !rsp_stall;
      for (int i = NSTG - 2; i >= 0; i--) begin
         adv[i] = !v_ff[i] || adv[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int i = 1; i < NSTG; i++) begin
            if (adv[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   assign req_stall = !adv[0];

   // stage 0: wrap angle, fold to quarter wave, clamp q to half bus
   s0_type s0_ff, s0_in;

   always_comb begin
      logic [31:0]        t;
      logic [31:0]        tt;
      logic [14:0]        zr;
      logic signed [17:0] q2w;
      logic signed [17:0] busw;
      t = {req_payload.elec_angle[ANGLE_FRAC_BITS-1:0], {(32-ANGLE_FRAC_BITS){1'b0}}};
      s0_in = '0;
      for (int k = 0; k < 2; k++) begin
         tt = (k == 0) ? t : t + 32'h4000_0000;
         zr = tt[29:15];
         s0_in.z[k]   = tt[30] ? 16'(SIN_ONE) - {1'b0, zr} : {1'b0, zr};
         s0_in.neg[k] = tt[31];
      end
      q2w  = {req_payload.q_voltage[15], req_payload.q_voltage, 1'b0};
      busw = $signed({2'b00, bus_ff});
      if (q2w > busw) begin
         q2w = busw;
      end else if (q2w < -busw) begin
         q2w = -busw;
      end
      s0_in.q2 = 17'(q2w);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) s0_ff <= s0_in;
   end

   // stage 1: z^2
   s1_type s1_ff, s1_in;

   always_comb begin
      logic [31:0] p;
      s1_in.z   = s0_ff.z;
      s1_in.neg = s0_ff.neg;
      s1_in.q2  = s0_ff.q2;
      for (int k = 0; k < 2; k++) begin
         p = 32'(s0_ff.z[k]) * 32'(s0_ff.z[k]);
         s1_in.z2[k] = p[30:15];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) s1_ff <= s1_in;
   end

   // stage 2: B - C*z^2
   s2_type s2_ff, s2_in;

   always_comb begin
      logic [31:0] p;
      s2_in.z   = s1_ff.z;
      s2_in.z2  = s1_ff.z2;
      s2_in.neg = s1_ff.neg;
      s2_in.q2  = s1_ff.q2;
      for (int k = 0; k < 2; k++) begin
         p = 32'(SIN_C) * 32'(s1_ff.z2[k]);
         s2_in.r1[k] = 16'(SIN_B) - p[30:15];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) s2_ff <= s2_in;
   end

   // stage 3: A - r1*z^2
   s3_type s3_ff, s3_in;

   always_comb begin
      logic [31:0] p;
      s3_in.z   = s2_ff.z;
      s3_in.neg = s2_ff.neg;
      s3_in.q2  = s2_ff.q2;
      for (int k = 0; k < 2; k++) begin
         p = 32'(s2_ff.r1[k]) * 32'(s2_ff.z2[k]);
         s3_in.r2[k] = 16'(SIN_A) - p[30:15];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3]) s3_ff <= s3_in;
   end

   // stage 4: r2*z, limit to one, apply sign
   s4_type s4_ff, s4_in;

   always_comb begin
      logic [31:0] p;
      logic [16:0] mag;
      s4_in.q2 = s3_ff.q2;
      for (int k = 0; k < 2; k++) begin
         p   = 32'(s3_ff.r2[k]) * 32'(s3_ff.z[k]);
         mag = (p[31:15] > 17'(SIN_ONE)) ? 17'(SIN_ONE) : p[31:15];
         s4_in.sc[k] = s3_ff.neg[k] ? -mag : mag;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[4]) s4_ff <= s4_in;
   end

   // stage 5: inverse Park with d = 0
   s5_type s5_ff, s5_in;

   always_comb begin
      logic signed [33:0] ps;
      ps = 34'(s4_ff.q2) * 34'($signed(s4_ff.sc[0]));
      s5_in.alpha = -ps;
      s5_in.beta  = 34'(s4_ff.q2) * 34'($signed(s4_ff.sc[1]));
   end

   always_ff @(posedge clock) begin
      if (adv[5]) s5_ff <= s5_in;
   end

   // stage 6: sqrt(3)*beta with round half up
   s6_type s6_ff, s6_in;

   always_comb begin
      s6_in.alpha = s5_ff.alpha;
      s6_in.bm    = 52'(s5_ff.beta) * 52'(SQRT3_Q16) + 52'sd32768;
   end

   always_ff @(posedge clock) begin
      if (adv[6]) s6_ff <= s6_in;
   end

   // stage 7: inverse Clarke plus mid-rail, saturation checks
   div_type s7_ff, s7_in;
   logic [32:0] den;

   assign den = {bus_ff, 17'h0};

   always_comb begin
      logic signed [37:0] s3b;
      logic signed [37:0] al;
      logic signed [37:0] offs;
      logic signed [37:0] dens;
      logic signed [37:0] u [NUM_PHASES];
      s3b  = 38'(s6_ff.bm >>> 16);
      al   = 38'(s6_ff.alpha);
      offs = $signed({6'h0, bus_ff, 16'h0});
      dens = $signed({5'h0, den});
      u[0] = (al <<< 1) + offs;
      u[1] = s3b - al + offs;
      u[2] = -al - s3b + offs;
      s7_in = '0;
      for (int p = 0; p < NUM_PHASES; p++) begin
         s7_in.zero[p] = (u[p] <= 38'sd0);
         s7_in.full[p] = (u[p] >= dens);
         s7_in.rem[p]  = (s7_in.zero[p] || s7_in.full[p]) ? '0 : u[p][REM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[7]) s7_ff <= s7_in;
   end

   // divider: one quotient bit per stage
   div_type dv [DUTY_BITS+1];

   assign dv[0] = s7_ff;

   for (genvar g = 0; g < DUTY_BITS; g++) begin : g_div
      fvpd_div_step u_step (
         .clock (clock),
         .reset (reset),
         .en    (adv[NARITH+g]),
         .den   (den),
         .d_in  (dv[g]),
         .d_out (dv[g+1])
      );
   end

   // output register
   rsp_type rsp_ff, rsp_in;

   always_comb begin
      logic [NUM_PHASES-1:0][15:0] dty;
      for (int p = 0; p < NUM_PHASES; p++) begin
         if (dv[DUTY_BITS].zero[p]) begin
            dty[p] = '0;
         end else if (dv[DUTY_BITS].full[p]) begin
            dty[p] = 16'({DUTY_BITS{1'b1}});
         end else begin
            dty[p] = 16'(dv[DUTY_BITS].quo[p]);
         end
      end
      rsp_in.duty_a = dty[0];
      rsp_in.duty_b = dty[1];
      rsp_in.duty_c = dty[2];
   end

   always_ff @(posedge clock) begin
      if (adv[NSTG-1]) rsp_ff <= rsp_in;
   end

   assign rsp_valid   = v_ff[NSTG-1];
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

>>> design/fvpd_checker.sv
// Port-level checks for the FOC voltage to phase duty block, bound to the top.
// Depends on fvpd_pkg and foc_voltage_to_phase_duty_top.
`default_nettype none

module fvpd_checker
   import fvpd_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_stall,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire rsp_type               rsp_payload,
   input wire logic [31:0]           csr_prdata
);

   // an empty pipeline after reset takes requests at once
   a_stall_after_reset: assert property (@(posedge clock) reset |=> !req_stall)
      else $error("req_stall high right after reset");

   a_no_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   a_prdata_upper: assert property (@(posedge clock) csr_prdata[31:16] == 16'h0)
      else $error("csr read data has upper bits set");

endmodule

bind foc_voltage_to_phase_duty_top fvpd_checker u_fvpd_checker (.*);

`default_nettype wire

>>> tb/sv/foc_voltage_to_phase_duty_top_test.sv
// Testbench for foc_voltage_to_phase_duty_top: random and directed angle/voltage
// transactions checked against a fixed-point phase duty predictor.
// Depends on fvpd_pkg and the design files.
`default_nettype none

module foc_voltage_to_phase_duty_top_test;
   import fvpd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 20000;
   localparam int PIPE_DEPTH = 25;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_payload;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   foc_voltage_to_phase_duty_top dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   req_type pending_reqs[$];
   rsp_type expected_duties[$];
   logic [15:0] bus_setting = BUS_RESET;
   logic req_taken = 1'b0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatches = 0;
   int quiet_cycles = 0;

   function automatic logic [31:0] quarter_sine(logic [31:0] z);
      logic [31:0] z2, r;
      z2 = (z * z) >> 15;
      r = (SIN_C * z2) >> 15;
      r = SIN_B - r;
      r = (r * z2) >> 15;
      r = SIN_A - r;
      r = (r * z) >> 15;
      return (r > 32768) ? 32'd32768 : r;
   endfunction

   function automatic longint turn_sine(logic [31:0] t);
      logic [31:0] z, s;
      z = {17'd0, t[29:15]};
      s = t[30] ? quarter_sine(32768 - z) : quarter_sine(z);
      return t[31] ? -longint'(s) : longint'(s);
   endfunction

   function automatic logic [15:0] phase_duty(longint u, logic [15:0] bus);
      longint den;
      den = longint'(bus) << 17;
      if (u <= 0) return 16'd0;
      if (u >= den) return 16'((longint'(1) << DUTY_BITS) - 1);
      return 16'((u << DUTY_BITS) / den);
   endfunction

   function automatic rsp_type predict_duties(req_type r, logic [15:0] bus);
      rsp_type d;
      logic [31:0] t;
      longint q2, sn, cs, alpha, beta, s3b, offs;
      d = '0;
      if (bus == 0) return d;
      t = 32'(r.elec_angle[ANGLE_FRAC_BITS-1:0]) << (32 - ANGLE_FRAC_BITS);
      q2 = 2 * longint'(r.q_voltage);
      if (q2 > longint'(bus)) q2 = bus;
      if (q2 < -longint'(bus)) q2 = -longint'(bus);
      sn = turn_sine(t);
      cs = turn_sine(t + 32'h4000_0000);
      alpha = -(q2 * sn);
      beta = q2 * cs;
      s3b = (beta * SQRT3_Q16 + 32768) >>> 16;
      offs = longint'(bus) << 16;
      d.duty_a = phase_duty(2 * alpha + offs, bus);
      d.duty_b = phase_duty(s3b - alpha + offs, bus);
      d.duty_c = phase_duty(-alpha - s3b + offs, bus);
      return d;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      mismatches++;
   endtask

   // driver: present the next transaction, hold while stalled
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_payload <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // predict on request acceptance, check on response acceptance
   always @(posedge clock) begin
      if (!reset) begin
         req_taken <= req_valid && !req_stall;
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (req_valid && !req_stall) begin
            expected_duties.push_back(predict_duties(req_payload, bus_setting));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_duties.size() == 0) begin
               report_mismatch("unexpected response", rsp_payload.duty_a, 16'd0);
            end else begin
               rsp_type want;
               want = expected_duties.pop_front();
               if (rsp_payload.duty_a !== want.duty_a)
                  report_mismatch("duty_a", rsp_payload.duty_a, want.duty_a);
               if (rsp_payload.duty_b !== want.duty_b)
                  report_mismatch("duty_b", rsp_payload.duty_b, want.duty_b);
               if (rsp_payload.duty_c !== want.duty_c)
                  report_mismatch("duty_c", rsp_payload.duty_c, want.duty_c);
            end
         end
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   task automatic write_bus(logic [15:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {CSR_ADDR_W{1'b0}} | CSR_IDX_BUS_VOLTAGE;
      csr_pwdata <= {16'($urandom_range(65535)), value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      bus_setting = value;
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || expected_duties.size() > 0 || req_valid)
         @(posedge clock);
      repeat (PIPE_DEPTH + 5) @(posedge clock);
   endtask

   function automatic req_type make_req(logic [31:0] angle, logic [15:0] q);
      req_type r;
      r.elec_angle = angle;
      r.q_voltage = q;
      return r;
   endfunction

   task automatic queue_random(int count);
      for (int i = 0; i < count; i++) begin
         logic [15:0] q;
         case ($urandom_range(3))
            0: q = 16'($urandom_range(65535));
            1: q = 16'($urandom_range(2 * bus_setting + 2)) - 16'(bus_setting + 1);
            2: q = $urandom_range(1) ? 16'h7FFF : 16'h8000;
            default: q = 16'($urandom_range(600)) - 16'd300;
         endcase
         pending_reqs.push_back(make_req($urandom, q));
      end
   endtask

   logic [15:0] bus_plan[6] = '{16'd3072, 16'd0, 16'hFFFF, 16'd1, 16'd6144, 16'd256};

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed: extremes of angle and voltage, quadrant edges, clamp
      foreach (bus_plan[k]) begin
         if (k > 0) write_bus(bus_plan[k]);
         if (k == 0 || k == 1 || k == 2) begin
            pending_reqs.push_back(make_req(32'h0000_0000, 16'h0000));
            pending_reqs.push_back(make_req(32'h7FFF_FFFF, 16'h7FFF));
            pending_reqs.push_back(make_req(32'h8000_0000, 16'h8000));
            pending_reqs.push_back(make_req(32'hFFFF_4000, 16'h0C00));
            pending_reqs.push_back(make_req(32'h0000_8000, 16'hF400));
            pending_reqs.push_back(make_req(32'h1234_C000, 16'h0600));
            pending_reqs.push_back(make_req(32'h0000_5555, 16'h0601));
            pending_reqs.push_back(make_req(32'h0000_FFFF, 16'hFFFF));
         end
         send_idle_pct = (k % 3 == 0) ? 28 : (k % 3 == 1) ? 88 : 0;
         recv_idle_pct = (k % 3 == 0) ? 88 : (k % 3 == 1) ? 28 : 0;
         queue_random(140);
         drain();
      end
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
